FILE: src/fwmm_pkg.sv
// ----------------------------------------------------------------------------
// fwmm_pkg
// Shared types and constants for the queue with running minimum and maximum.
// ----------------------------------------------------------------------------
`default_nettype none

package fwmm_pkg;

    localparam int VAL_W       = 31;
    localparam int DEF_DEPTH   = 16;
    localparam int ERR_W       = 2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef logic [VAL_W-1:0] fwmm_val_t;

    typedef struct packed {
        logic      shift;
        logic      load;
        fwmm_val_t value;
    } fwmm_op_t;

    typedef struct packed {
        logic      has;
        fwmm_val_t lo;
        fwmm_val_t hi;
    } fwmm_red_t;

endpackage

`default_nettype wire

FILE: src/fwmm_cell.sv
// ----------------------------------------------------------------------------
// fwmm_cell
// One queue slot: holds an entry, shifts toward the head on a pop, loads on a
// push at its own position, and folds its entry into the passing min/max wave.
// ----------------------------------------------------------------------------
`default_nettype none

module fwmm_cell
    import fwmm_pkg::*;
#(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  wire logic             aclk,
    input  wire fwmm_op_t         op,
    input  wire logic [CNT_W-1:0] count,
    input  wire fwmm_val_t        shift_in,
    input  wire fwmm_red_t        red_in,
    output fwmm_val_t             entry,
    output fwmm_red_t             red_out
);

    fwmm_val_t entry_reg;
    fwmm_red_t red_reg;
    fwmm_red_t red_next;
    logic      occupied;

    assign occupied = CNT_W'(IDX) < count;

    always_comb begin
        red_next = red_in;
        if (occupied) begin
            if (!red_in.has) begin
                red_next.has = 1'b1;
                red_next.lo  = entry_reg;
                red_next.hi  = entry_reg;
            end else begin
                if (entry_reg < red_in.lo) begin
                    red_next.lo = entry_reg;
                end
                if (entry_reg > red_in.hi) begin
                    red_next.hi = entry_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op.shift) begin
            entry_reg <= shift_in;
        end else if (op.load && (CNT_W'(IDX) == count)) begin
            entry_reg <= op.value;
        end
        red_reg <= red_next;
    end

    assign entry   = entry_reg;
    assign red_out = red_reg;

endmodule

`default_nettype wire

FILE: src/fifo_with_min_max.sv
// ----------------------------------------------------------------------------
// fifo_with_min_max
// Queue of order numbers that reports popped value, count, minimum, maximum and
// error per beat.
// An input beat is taken in IDLE; the min/max wave then passes one cell per cycle
// along the chain of queue cells in SWEEP, and DONE registers the result beat. No
// new input beat is taken until the result of the last one has been registered.
// A result waiting on the output does not block the next input beat, but that
// beat's result holds the input off until the waiting one has been taken.
// Reset (aresetn low, synchronous) empties the queue and clears the handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_min_max
    import fwmm_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_DEPTH,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_W       = ((3 * VAL_W + CNT_W + ERR_W + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [31:0]      s_tdata,   // order_value
    input  wire logic             s_tuser,   // action
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // popped_value, smallest, largest,
                                             // entry_count, error
    output logic                  m_tuser    // popped_valid
);

    localparam int SW_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LO_B  = VAL_W;
    localparam int HI_B  = 2 * VAL_W;
    localparam int CNT_B = 3 * VAL_W;
    localparam int ERR_B = 3 * VAL_W + CNT_W;

    typedef enum logic [1:0] {
        IDLE,
        SWEEP,
        DONE
    } state_t;

    state_t               state_reg,  state_next;
    logic [SW_W-1:0]      sweep_reg,  sweep_next;
    logic [CNT_W-1:0]     count_reg,  count_next;
    fwmm_val_t            popped_reg, popped_next;
    logic                 pvalid_reg, pvalid_next;
    logic [ERR_W-1:0]     err_reg,    err_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg,  m_tdata_next;
    logic                 m_tuser_reg,  m_tuser_next;

    fwmm_op_t             op;
    fwmm_val_t            entry_w [QUEUE_DEPTH];
    fwmm_red_t            red_w   [QUEUE_DEPTH];
    logic                 accept;
    logic                 is_pop;
    logic                 full;
    logic                 empty;
    logic                 out_free;
    fwmm_red_t            result;

    assign s_tready = aresetn && (state_reg == IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_pop   = (s_tuser == ACT_POP);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign result   = red_w[QUEUE_DEPTH-1];

    assign op.shift = accept && is_pop && !empty;
    assign op.load  = accept && !is_pop && !full;
    assign op.value = s_tdata[VAL_W-1:0];

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        fwmm_val_t shift_in;
        fwmm_red_t red_in;

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign shift_in = entry_w[k];
        end else begin : g_body
            assign shift_in = entry_w[k+1];
        end

        if (k == 0) begin : g_head
            assign red_in = '0;
        end else begin : g_link
            assign red_in = red_w[k-1];
        end

        fwmm_cell #(
            .CNT_W (CNT_W),
            .IDX   (k)
        ) u_cell (
            .aclk     (aclk),
            .op       (op),
            .count    (count_reg),
            .shift_in (shift_in),
            .red_in   (red_in),
            .entry    (entry_w[k]),
            .red_out  (red_w[k])
        );
    end

    always_comb begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        count_next    = count_reg;
        popped_next   = popped_reg;
        pvalid_next   = pvalid_reg;
        err_next      = err_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE: begin
                if (accept) begin
                    popped_next = '0;
                    pvalid_next = 1'b0;
                    err_next    = ERR_OK;
                    if (is_pop) begin
                        if (empty) begin
                            err_next = ERR_EMPTY;
                        end else begin
                            popped_next = entry_w[0];
                            pvalid_next = 1'b1;
                            count_next  = count_reg - 1'b1;
                        end
                    end else begin
                        if (full) begin
                            err_next = ERR_FULL;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    sweep_next = '0;
                    state_next = SWEEP;
                end
            end
            SWEEP: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SW_W'(QUEUE_DEPTH - 1)) begin
                    state_next = DONE;
                end
            end
            DONE: begin
                if (out_free) begin
                    m_tdata_next                    = '0;
                    m_tdata_next[VAL_W-1:0]         = popped_reg;
                    m_tdata_next[LO_B +: VAL_W]     = result.has ? result.lo : '0;
                    m_tdata_next[HI_B +: VAL_W]     = result.has ? result.hi : '0;
                    m_tdata_next[CNT_B +: CNT_W]    = count_reg;
                    m_tdata_next[ERR_B +: ERR_W]    = err_reg;
                    m_tuser_next                    = pvalid_reg;
                    m_tvalid_next                   = 1'b1;
                    state_next                      = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            sweep_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        popped_reg  <= popped_next;
        pvalid_reg  <= pvalid_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_pop && empty |=> err_reg == ERR_EMPTY && count_reg == '0)
        else $error("pop on empty queue not flagged");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_pop && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not advance the count");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second beat taken during a sweep");

endmodule

`default_nettype wire

FILE: sim/fifo_with_min_max_tb.sv
// ----------------------------------------------------------------------------
// fifo_with_min_max_tb
// Self-checking bench for the order-number queue with running min and max.
// Pushes and pops are streamed in with random gaps and the results are
// streamed out against random and long back-pressure. Every result beat is
// compared field by field with a behavioural copy of the queue kept here.
// ----------------------------------------------------------------------------
module fifo_with_min_max_tb
    import fwmm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = DEF_DEPTH;
    localparam int CNT_W       = 5;
    localparam int OUT_W       = 104;
    localparam int POP_LSB     = 0;
    localparam int LO_LSB      = VAL_W;
    localparam int HI_LSB      = 2 * VAL_W;
    localparam int CNT_LSB     = 3 * VAL_W;
    localparam int ERR_LSB     = 3 * VAL_W + CNT_W;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam fwmm_val_t VAL_MAX = {VAL_W{1'b1}};

    typedef struct packed {
        fwmm_val_t        popped;
        logic             popped_ok;
        fwmm_val_t        lo;
        fwmm_val_t        hi;
        logic [CNT_W-1:0] count;
        logic [ERR_W-1:0] err;
    } order_result_t;

    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata  = '0;
    logic             s_tuser  = ACT_PUSH;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;

    fwmm_val_t     held_orders[$];
    order_result_t awaited_results[$];
    int            fail_count       = 0;
    int            cycle_count      = 0;
    int            tx_gap_pct       = 25;
    int            rx_stall_pct     = 10;
    int            rx_gap           = 0;
    int            hold_cycles_left = 0;
    logic          hold_request     = 1'b0;
    logic          calm_tail        = 1'b0;

    fifo_with_min_max u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic order_result_t apply_order_step(input logic act,
                                                       input fwmm_val_t value);
        order_result_t r;
        r     = '0;
        r.err = ERR_OK;
        if (act == ACT_PUSH) begin
            if (held_orders.size() >= QUEUE_DEPTH)
                r.err = ERR_FULL;
            else
                held_orders.push_back(value);
        end else begin
            if (held_orders.size() == 0) begin
                r.err = ERR_EMPTY;
            end else begin
                r.popped    = held_orders.pop_front();
                r.popped_ok = 1'b1;
            end
        end
        if (held_orders.size() != 0) begin
            r.lo = held_orders[0];
            r.hi = held_orders[0];
            foreach (held_orders[k]) begin
                if (held_orders[k] < r.lo)
                    r.lo = held_orders[k];
                if (held_orders[k] > r.hi)
                    r.hi = held_orders[k];
            end
        end
        r.count = CNT_W'(held_orders.size());
        return r;
    endfunction

    function automatic fwmm_val_t random_order();
        fwmm_val_t v;
        case ($urandom_range(4))
            0: v = $urandom_range(1) ? VAL_MAX : '0;
            1: v = fwmm_val_t'($urandom_range(15));
            2: v = VAL_MAX - fwmm_val_t'($urandom_range(15));
            default: v = fwmm_val_t'($urandom());
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got,
                 want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, 64'(got), 64'(want));
    endtask

    task automatic send_order(input logic act, input fwmm_val_t value);
        if ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, value};
        do @(posedge aclk); while (!s_tready);
        awaited_results.push_back(apply_order_step(act, value));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_empty_pop();
        send_order(ACT_POP, VAL_MAX);
        send_order(ACT_POP, '0);
    endtask

    task automatic test_extremes();
        send_order(ACT_PUSH, VAL_MAX);
        send_order(ACT_PUSH, '0);
        send_order(ACT_PUSH, 31'd1);
        send_order(ACT_POP, '0);
        send_order(ACT_POP, '0);
        send_order(ACT_POP, '0);
    endtask

    task automatic test_fill_to_full();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_order(ACT_PUSH, i[0] ? 31'h2AAA_AAAA : 31'h5555_5555 - fwmm_val_t'(i));
        send_order(ACT_PUSH, 31'h1234_5678);
    endtask

    task automatic test_backpressure();
        @(posedge aclk);
        hold_request <= 1'b1;
        @(posedge aclk);
        hold_request <= 1'b0;
        for (int i = 0; i < 40; i++)
            send_order($urandom_range(99) < 60 ? ACT_PUSH : ACT_POP, random_order());
        wait_drained();
    endtask

    task automatic test_random_mix();
        int push_pct;
        for (int seg = 0; seg < 20; seg++) begin
            case ($urandom_range(3))
                0: push_pct = 20;
                1: push_pct = 50;
                2: push_pct = 80;
                default: push_pct = 95;
            endcase
            case ($urandom_range(2))
                0: tx_gap_pct = 0;
                1: tx_gap_pct = 15;
                default: tx_gap_pct = 40;
            endcase
            if (seg >= 18) begin
                tx_gap_pct = 0;
                calm_tail <= 1'b1;
            end
            for (int i = 0; i < 25; i++)
                send_order($urandom_range(99) < push_pct ? ACT_PUSH : ACT_POP,
                           random_order());
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fifo_with_min_max_tb NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cycle_count % 256 == 0) begin
            case ($urandom_range(2))
                0: rx_stall_pct <= 0;
                1: rx_stall_pct <= 10;
                default: rx_stall_pct <= 35;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (hold_cycles_left != 0)
            hold_cycles_left <= hold_cycles_left - 1;
        else if (hold_request)
            hold_cycles_left <= HOLD_CYCLES;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else if (hold_cycles_left != 0 || rx_gap != 0) begin
            m_tready <= 1'b0;
            if (rx_gap != 0)
                rx_gap <= rx_gap - 1;
        end else if (!calm_tail && $urandom_range(99) < rx_stall_pct) begin
            m_tready <= 1'b0;
            rx_gap   <= $urandom_range(0, 11);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        order_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata[63:0], '0);
            end else begin
                want = awaited_results.pop_front();
                check_field("popped_value", 32'(m_tdata[POP_LSB +: VAL_W]),
                            32'(want.popped));
                check_field("popped_valid", 32'(m_tuser), 32'(want.popped_ok));
                check_field("smallest", 32'(m_tdata[LO_LSB +: VAL_W]), 32'(want.lo));
                check_field("largest", 32'(m_tdata[HI_LSB +: VAL_W]), 32'(want.hi));
                check_field("entry_count", 32'(m_tdata[CNT_LSB +: CNT_W]),
                            32'(want.count));
                check_field("error", 32'(m_tdata[ERR_LSB +: ERR_W]), 32'(want.err));
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_pop();
        test_extremes();
        test_fill_to_full();
        test_backpressure();
        test_random_mix();
        wait_drained();
        repeat (QUEUE_DEPTH + 8) @(posedge aclk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("fifo_with_min_max_tb OK");
        else
            $display("fifo_with_min_max_tb NOT OK");
        $finish;
    end

endmodule
